[rtl/fsat_pkg.sv]
// shared types and constants of the floppy sector address translator
`timescale 1ns / 1ps
package fsat_pkg;

	localparam int LSEC_W    = 16;
	localparam int SPT_W     = 8;
	localparam int HEADS_W   = 2;
	localparam int TRACKS_W  = 8;
	localparam int SIZE_W    = 2;
	localparam int START_W   = 8;
	localparam int BYTES_W   = 16;
	localparam int TRACK_W   = 8;
	localparam int SECTOR_W  = 8;
	localparam int MAXS_W    = 8;
	localparam int TOTAL_W   = 17;
	localparam int PROD_W    = TRACKS_W + SPT_W;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	// smallest sector is 128 bytes, larger sizes double per code step
	localparam int SIZE_SHIFT_BASE = 7;
	localparam int BUDGET_Q_W      = BYTES_W - SIZE_SHIFT_BASE;
	localparam int END_W           = BUDGET_Q_W + 1;

	localparam int DEF_BUFFER_BYTES = 4096;

	localparam logic [SPT_W-1:0]    RST_SPT    = 8'd18;
	localparam logic [HEADS_W-1:0]  RST_HEADS  = 2'd2;
	localparam logic [TRACKS_W-1:0] RST_TRACKS = 8'd80;
	localparam logic                RST_DSTEP  = 1'b0;
	localparam logic [SIZE_W-1:0]   RST_SIZE   = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPT    = 3'd0,
		CFG_HEADS  = 3'd1,
		CFG_TRACKS = 3'd2,
		CFG_DSTEP  = 3'd3,
		CFG_SIZE   = 3'd4
	} fsat_cfg_idx_t;

	typedef enum logic {
		CMD_TRANSLATE = 1'b0,
		CMD_MAX_COUNT = 1'b1
	} fsat_cmd_t;

	// partial remainder, dividend turning into quotient, divisor
	typedef struct packed {
		logic [SPT_W-1:0]  rem;
		logic [LSEC_W-1:0] dvd;
		logic [SPT_W-1:0]  div;
	} fsat_div_t;

	typedef struct packed {
		fsat_cmd_t         cmd;
		logic              spt_zero;
		logic [LSEC_W-1:0] lsec;
		logic [MAXS_W-1:0] maxs;
	} fsat_item_t;

endpackage

[rtl/fsat_div_cell.sv]
// one restoring division step with its own pipeline register
`timescale 1ns / 1ps
module fsat_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsat_pkg::fsat_div_t  in_div,
	input  fsat_pkg::fsat_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fsat_pkg::fsat_div_t  out_div,
	output fsat_pkg::fsat_item_t out_item
);
	import fsat_pkg::*;

	logic              valid_q;
	fsat_div_t         div_q;
	fsat_item_t        item_q;
	logic              adv;
	logic [SPT_W:0]    trial;
	logic [SPT_W:0]    diff;
	logic              ge;
	fsat_div_t         div_next;

	assign adv      = !valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		trial = {in_div.rem, in_div.dvd[LSEC_W-1]};
		diff  = trial - {1'b0, in_div.div};
		ge    = (trial >= {1'b0, in_div.div});
		div_next.div = in_div.div;
		div_next.dvd = {in_div.dvd[LSEC_W-2:0], ge};
		div_next.rem = ge ? diff[SPT_W-1:0] : trial[SPT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			div_q  <= div_next;
			item_q <= in_item;
		end
	end

	assign out_valid = valid_q;
	assign out_div   = div_q;
	assign out_item  = item_q;

endmodule

[rtl/floppy_sector_address_translator.sv]
// top level: geometry registers, division cell row and result register
//
// Input channel s_axis: one request per transfer, command in tuser, operands in
// tdata. Output channel m_axis: one result per request, in request order.
// Configuration: cfg_we with cfg_index and cfg_data writes one geometry
// register at the clock edge; indexes beyond the register list are ignored.
// Path: a request accepted on s_axis passes through the 16 division cells,
// the first cell loading at the accepting edge, and then the result register
// before its result shows on m_axis.
// Throughput: one request per cycle while m_axis_tready stays high; the row
// of 16 division cells, one quotient bit each, is fully pipelined.
// Reset (arst_n low) empties every stage and loads the default geometry of
// 18 sectors, 2 heads, 80 tracks, single stepping and 512-byte sectors.
// When the receiver stalls the result holds on m_axis; requests are still
// taken while any stage behind it is empty, and s_axis_tready drops once
// the whole row is full.
`timescale 1ns / 1ps
module floppy_sector_address_translator #(
	parameter int BUFFER_BYTES = fsat_pkg::DEF_BUFFER_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fsat_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsat_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// logical_sector, start_sector, transfer_bytes
	input  logic [fsat_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// command
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// track, head, sector, beyond_disk, max_sectors, total_sectors, zero fill
	output logic [fsat_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import fsat_pkg::*;

	localparam int NCELL = LSEC_W;

	logic [SPT_W-1:0]    spt_q;
	logic [HEADS_W-1:0]  heads_q;
	logic [TRACKS_W-1:0] tracks_q;
	logic                dstep_q;
	logic [SIZE_W-1:0]   size_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [LSEC_W-1:0]     in_lsec;
	logic [START_W-1:0]    in_start;
	logic [BYTES_W-1:0]    in_bytes;
	logic [BYTES_W-1:0]    budget;
	logic [BUDGET_Q_W-1:0] budget_q;
	logic [END_W-1:0]      end_sec;
	logic [END_W-1:0]      end_clamp;
	logic [END_W-1:0]      span;
	logic                  start_ok;
	logic [TRACKS_W-1:0]   eff_tracks;
	logic [PROD_W-1:0]     prod;
	logic                  two_heads;

	fsat_div_t  div_c   [NCELL+1];
	fsat_item_t item_c  [NCELL+1];
	logic       valid_c [NCELL+1];
	logic       ready_c [NCELL+1];

	logic                 out_valid_q;
	logic [TRACK_W-1:0]   track_q;
	logic                 head_q;
	logic [SECTOR_W-1:0]  sector_q;
	logic                 beyond_q;
	logic [MAXS_W-1:0]    maxs_q;
	logic [TOTAL_W-1:0]   total_out_q;
	fsat_cmd_t            cmd_q;
	logic                 out_adv;
	logic [LSEC_W-1:0]    quo;
	logic [LSEC_W-1:0]    trk_full;
	logic [TRACK_W-1:0]   trk_adj;
	logic                 res_head;
	logic                 res_beyond;
	fsat_item_t           last_item;

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q    <= RST_SPT;
			heads_q  <= RST_HEADS;
			tracks_q <= RST_TRACKS;
			dstep_q  <= RST_DSTEP;
			size_q   <= RST_SIZE;
		end else if (cfg_we) begin
			case (fsat_cfg_idx_t'(cfg_index))
				CFG_SPT:    spt_q    <= cfg_data[SPT_W-1:0];
				CFG_HEADS:  heads_q  <= cfg_data[HEADS_W-1:0];
				CFG_TRACKS: tracks_q <= cfg_data[TRACKS_W-1:0];
				CFG_DSTEP:  dstep_q  <= cfg_data[0];
				CFG_SIZE:   size_q   <= cfg_data[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	// head count 0 acts as 1, 3 acts as 2
	assign two_heads  = heads_q[1];
	assign eff_tracks = dstep_q ? {1'b0, tracks_q[TRACKS_W-1:1]} : tracks_q;
	assign prod       = eff_tracks * spt_q;

	always_ff @(posedge clk) begin
		total_q <= two_heads ? {prod, 1'b0} : {1'b0, prod};
	end

	// request unpacking and transfer count
	assign in_lsec  = s_axis_tdata[LSEC_W-1:0];
	assign in_start = s_axis_tdata[LSEC_W +: START_W];
	assign in_bytes = s_axis_tdata[LSEC_W+START_W +: BYTES_W];

	always_comb begin
		budget    = (in_bytes == '0) ? BYTES_W'(BUFFER_BYTES) : in_bytes;
		budget_q  = BUDGET_Q_W'(budget >> (SIZE_SHIFT_BASE + int'(size_q)));
		start_ok  = (in_start != '0) && (in_start <= spt_q);
		end_sec   = END_W'(in_start) + END_W'(budget_q) - END_W'(1);
		end_clamp = (end_sec > END_W'(spt_q)) ? END_W'(spt_q) : end_sec;
		span      = end_clamp + END_W'(1) - END_W'(in_start);
	end

	always_comb begin
		valid_c[0]       = s_axis_tvalid;
		div_c[0].rem     = '0;
		div_c[0].dvd     = in_lsec;
		div_c[0].div     = spt_q;
		item_c[0].cmd    = fsat_cmd_t'(s_axis_tuser);
		item_c[0].spt_zero = (spt_q == '0);
		item_c[0].lsec   = in_lsec;
		item_c[0].maxs   = start_ok ? span[MAXS_W-1:0] : '0;
	end

	assign s_axis_tready = ready_c[0];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fsat_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_div    (div_c[i]),
			.in_item   (item_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_div   (div_c[i+1]),
			.out_item  (item_c[i+1])
		);
	end

	// result register
	assign out_adv        = !out_valid_q || m_axis_tready;
	assign ready_c[NCELL] = out_adv;
	assign last_item      = item_c[NCELL];
	assign quo            = div_c[NCELL].dvd;

	always_comb begin
		trk_full   = two_heads ? {1'b0, quo[LSEC_W-1:1]} : quo;
		res_head   = two_heads & quo[0];
		trk_adj    = trk_full[TRACK_W-1:0] + TRACK_W'(dstep_q & trk_full[0]);
		res_beyond = ({1'b0, last_item.lsec} >= total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_c[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_c[NCELL]) begin
			cmd_q       <= last_item.cmd;
			total_out_q <= total_q;
			maxs_q      <= '0;
			track_q     <= '0;
			head_q      <= 1'b0;
			sector_q    <= '0;
			beyond_q    <= 1'b0;
			if (last_item.cmd == CMD_MAX_COUNT) begin
				maxs_q <= last_item.maxs;
			end else begin
				beyond_q <= res_beyond;
				if (!last_item.spt_zero) begin
					track_q  <= trk_adj;
					head_q   <= res_head;
					sector_q <= div_c[NCELL].rem + SECTOR_W'(1);
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		{(OUT_DATA_W - TOTAL_W - MAXS_W - SECTOR_W - TRACK_W - 2){1'b0}},
		total_out_q, maxs_q, beyond_q, sector_q, head_q, track_q
	};

`ifndef ASSERT_OFF
	a_cmd1_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cmd_q == CMD_MAX_COUNT |->
			track_q == '0 && !head_q && sector_q == '0 && !beyond_q)
		else $error("count result carries an address");

	a_cmd0_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cmd_q == CMD_TRANSLATE |-> maxs_q == '0)
		else $error("translate result carries a transfer count");

	a_count_in_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> maxs_q <= spt_q)
		else $error("transfer count exceeds sectors per track");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[NCELL] && !last_item.spt_zero |-> div_c[NCELL].rem < div_c[NCELL].div)
		else $error("division remainder not below divisor");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[NCELL] && !out_adv |=> valid_c[NCELL] && $stable(last_item))
		else $error("last cell lost its item during a stall");
`endif

endmodule
